// ===== rtl/batch_median_finder_top_assert.svh =====
// Assertion macros for the batch median finder (clocked on i_clk, reset by i_rst_n).
`ifndef BATCH_MEDIAN_FINDER_TOP_ASSERT_SVH
`define BATCH_MEDIAN_FINDER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising edge outside reset.
`define BMF_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("bmf assertion failed");

// Same, with a caller message.
`define BMF_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`else

`define BMF_ASSERT(label, prop)
`define BMF_ASSERT_MSG(label, prop, msg)

`endif

`endif

// ===== rtl/bmf_pkg.sv =====
// Shared constants and types for the batch median finder.
package bmf_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int SAMPLE_W  = 32;
    localparam int MED_W     = 33;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int S_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((MED_W + 7) / 8) * 8;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [MED_W-1:0]    t_median;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;    // insert the broadcast sample in order
        logic shift;  // move every entry one cell toward the head
    } t_chain_ctl;

endpackage

// ===== rtl/bmf_cell.sv =====
// One compare-and-shift cell of the sorted chain.
module bmf_cell
    import bmf_pkg::*;
(
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    input  t_sample    i_sample,
    input  logic       i_occ,       // this cell holds a batch entry
    input  logic       i_prev_occ,  // cell toward the head holds an entry
    input  logic       i_prev_gt,   // cell toward the head is above the sample
    input  t_sample    i_prev_val,
    input  t_sample    i_next_val,
    output logic       o_gt,
    output t_sample    o_val
);

    t_sample r_val;
    t_sample n_val;
    logic    take;

    // Entry above the new sample: it moves up one place (stable for equal values)
    assign o_gt  = i_occ && (r_val > i_sample);
    assign take  = o_gt || (!i_occ && i_prev_occ);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && take) begin
            n_val = i_prev_gt ? i_prev_val : i_sample;
        end else if (i_ctl.shift) begin
            n_val = i_next_val;
        end
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ===== rtl/bmf_chain.sv =====
// Row of sorting cells; the head cells feed the median adder.
module bmf_chain
    import bmf_pkg::*;
(
    input  logic             i_clk,
    input  t_chain_ctl       i_ctl,
    input  t_sample          i_sample,
    input  logic [CNT_W-1:0] i_count,
    output t_sample          o_head0,
    output t_sample          o_head1
);

    logic    [MAX_ITEMS-1:0] occ;
    logic    [MAX_ITEMS-1:0] gt;
    t_sample                 val [MAX_ITEMS];

    // Occupancy is a thermometer of the fill count
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            occ[i] = i_count > CNT_W'(i);
        end
    end

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic    prev_occ;
        logic    prev_gt;
        t_sample prev_val;
        t_sample next_val;

        if (g == 0) begin : g_head
            assign prev_occ = 1'b1;
            assign prev_gt  = 1'b0;
            assign prev_val = i_sample;
        end else begin : g_body
            assign prev_occ = occ[g-1];
            assign prev_gt  = gt[g-1];
            assign prev_val = val[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign next_val = val[g];
        end else begin : g_mid
            assign next_val = val[g+1];
        end

        bmf_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_sample   (i_sample),
            .i_occ      (occ[g]),
            .i_prev_occ (prev_occ),
            .i_prev_gt  (prev_gt),
            .i_prev_val (prev_val),
            .i_next_val (next_val),
            .o_gt       (gt[g]),
            .o_val      (val[g])
        );
    end

    assign o_head0 = val[0];
    assign o_head1 = val[1];

endmodule

// ===== rtl/batch_median_finder_top.sv =====
// After the last beat of a batch, the chain shifts toward the head until the middle
// entry sits in the head cell; the result is then loaded once the output is free.
// Throughput: one sample per cycle within a batch; no sample is taken while the
// chain shifts the middle entry to its head and the result is loaded.
// Reset: i_rst_n synchronous, active low; clears fill count, overflow flag, state
// and the output valid. Cell contents are left as they are and never read unfilled.
module batch_median_finder_top
    import bmf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // [31:0] sample
    input  logic                 i_s_axis_tlast,   // is_last
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,   // [32:0] median_half_units, rest zero
    output logic                 o_m_axis_tuser    // overflowed
);

    `include "batch_median_finder_top_assert.svh"

    localparam logic ST_ACCEPT = 1'b0;
    localparam logic ST_SEEK   = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovf;
    logic             n_ovf;
    logic [IDX_W-1:0] r_left;
    logic [IDX_W-1:0] n_left;
    logic             r_odd;
    logic             n_odd;
    logic             r_m_valid;
    logic             n_m_valid;
    t_median          r_median;
    logic             r_m_ovf;

    logic             s_acc;
    logic             room;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] mid_lo;
    logic             load;
    t_chain_ctl       ctl;
    t_sample          sample;
    t_sample          head0;
    t_sample          head1;
    t_median          median;

    assign sample          = t_sample'(i_s_axis_tdata[SAMPLE_W-1:0]);
    assign o_s_axis_tready = (r_state == ST_ACCEPT);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign room            = r_count < CNT_W'(MAX_ITEMS);
    assign total           = r_count + CNT_W'(room);
    assign mid_lo          = (total - CNT_W'(1)) >> 1;

    // Chain command: insert on accepted beats with room, shift while seeking with shifts left
    assign ctl.ins   = s_acc && room;
    assign ctl.shift = (r_state == ST_SEEK) && (r_left != '0);

    bmf_chain u_chain (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_sample (sample),
        .i_count  (r_count),
        .o_head0  (head0),
        .o_head1  (head1)
    );

    // Median in half units from the two head cells
    assign median = r_odd ? {head0, 1'b0}
                          : ({head0[SAMPLE_W-1], head0} + {head1[SAMPLE_W-1], head1});

    assign load = (r_state == ST_SEEK) && (r_left == '0)
                  && (!r_m_valid || i_m_axis_tready);

    // Batch control
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_left    = r_left;
        n_odd     = r_odd;
        n_m_valid = r_m_valid;
        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            ST_ACCEPT: begin
                if (s_acc) begin
                    n_count = total;
                    n_ovf   = r_ovf || !room;
                    if (i_s_axis_tlast) begin
                        n_state = ST_SEEK;
                        n_left  = mid_lo[IDX_W-1:0];
                        n_odd   = total[0];
                    end
                end
            end
            ST_SEEK: begin
                if (r_left != '0) begin
                    n_left = r_left - IDX_W'(1);
                end else if (load) begin
                    n_m_valid = 1'b1;
                    n_count   = '0;
                    n_ovf     = 1'b0;
                    n_state   = ST_ACCEPT;
                end
            end
            default: begin
                n_state = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_ACCEPT;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_left    <= '0;
            r_odd     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_left    <= n_left;
            r_odd     <= n_odd;
            r_m_valid <= n_m_valid;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_median <= median;
            r_m_ovf  <= r_ovf;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = M_TDATA_W'({1'b0, r_median} & {1'b0, {MED_W{1'b1}}});
    assign o_m_axis_tuser  = r_m_ovf;

    // Checks
    `BMF_ASSERT(a_count_in_range, r_count <= CNT_W'(MAX_ITEMS))
    `BMF_ASSERT(a_last_stops_input, (s_acc && i_s_axis_tlast) |=> !o_s_axis_tready)
    `BMF_ASSERT_MSG(a_result_from_seek, $rose(r_m_valid) |-> $past(r_state == ST_SEEK), "result without seek")
    `BMF_ASSERT_MSG(a_batch_cleared, ($past(r_state == ST_SEEK) && r_state == ST_ACCEPT) |-> (r_count == '0 && !r_ovf), "batch not cleared")

endmodule

// ===== sim/batch_median_checker.sv =====
// Scoreboard for the batch median finder: tracks sample beats, predicts medians, checks results.
`timescale 1ns / 100ps

module batch_median_checker
    import bmf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [31:0] sample
    input  logic                 i_s_tlast,   // is_last
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,   // [32:0] median_half_units, rest zero
    input  logic                 i_m_tuser,   // overflowed
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        t_median med_half;
        logic    ovf;
    } median_result_t;

    // Shadow of the batch: ascending samples, fill level, dropped-sample flag
    t_sample        batch_store [MAX_ITEMS];
    int             fill_cnt;
    logic           overflow_seen;
    median_result_t median_q [$];
    int             fails;

    always @(posedge i_clk) begin : track
        int             pos;
        int             n;
        t_sample        smp;
        median_result_t want;

        if (!i_rst_n) begin
            fill_cnt      = 0;
            overflow_seen = 1'b0;
            median_q.delete();
        end else begin
            // Sample beat: insert in order, equal values stay in arrival order
            if (i_s_tvalid && i_s_tready) begin
                smp = i_s_tdata[SAMPLE_W-1:0];
                if (fill_cnt < MAX_ITEMS) begin
                    pos = fill_cnt;
                    while (pos > 0 && batch_store[pos-1] > smp) begin
                        batch_store[pos] = batch_store[pos-1];
                        pos--;
                    end
                    batch_store[pos] = smp;
                    fill_cnt++;
                end else begin
                    overflow_seen = 1'b1;
                end

                // Closing beat: median times two, formed at 33 bits
                if (i_s_tlast) begin
                    n = fill_cnt;
                    if (n % 2 == 1) begin
                        want.med_half = {batch_store[(n-1)/2], 1'b0};
                    end else begin
                        want.med_half = {batch_store[n/2][SAMPLE_W-1], batch_store[n/2]}
                            + {batch_store[n/2-1][SAMPLE_W-1], batch_store[n/2-1]};
                    end
                    want.ovf = overflow_seen;
                    median_q.push_back(want);
                    fill_cnt      = 0;
                    overflow_seen = 1'b0;
                end
            end

            // Result beat: compare with the oldest predicted median
            if (i_m_tvalid && i_m_tready) begin
                if (median_q.size() == 0) begin
                    $error("unexpected result beat: median_half_units=%0d overflowed=%0b",
                           $signed(i_m_tdata[MED_W-1:0]), i_m_tuser);
                    fails++;
                end else begin
                    want = median_q.pop_front();
                    if (i_m_tdata[MED_W-1:0] !== want.med_half) begin
                        $error("median_half_units: expected %0d, got %0d",
                               want.med_half, $signed(i_m_tdata[MED_W-1:0]));
                        fails++;
                    end
                    if (i_m_tuser !== want.ovf) begin
                        $error("overflowed: expected %0b, got %0b", want.ovf, i_m_tuser);
                        fails++;
                    end
                    if (i_m_tdata[M_TDATA_W-1:MED_W] !== '0) begin
                        $error("tdata padding: expected 0, got %0h",
                               i_m_tdata[M_TDATA_W-1:MED_W]);
                        fails++;
                    end
                end
            end
        end

        o_pending    <= median_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the batch median finder: clock, reset, sample traffic and verdict.
`timescale 1ns / 100ps

module tb_top;
    import bmf_pkg::*;

    localparam int TOTAL_SAMPLES = 1350;
    localparam int LONG_HOLD     = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    int                   fail_count;
    int                   medians_pending;

    int   tx_idle_pct  = 20;
    int   rx_stall_pct = 58;
    int   samples_sent = 0;
    logic long_hold_req = 1'b0;
    int   hold_left = 0;

    batch_median_finder_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    batch_median_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (medians_pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("** batch_median_finder_top: FAILED **");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    always @(posedge clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Sample choice: 0 full range, 1 narrow range with many ties, 2 extremes
    function automatic t_sample pick_sample(int flavor);
        case (flavor)
            0: pick_sample = $urandom;
            1: pick_sample = $signed($urandom_range(16)) - 8;
            default: begin
                case ($urandom_range(3))
                    0: pick_sample = 32'sh7FFF_FFFF;
                    1: pick_sample = 32'sh8000_0000;
                    2: pick_sample = 32'sd0;
                    default: pick_sample = -32'sd1;
                endcase
            end
        endcase
    endfunction

    // One sample beat, with random idle cycles ahead of it
    task automatic send_sample(t_sample smp, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        samples_sent++;
    endtask

    task automatic send_batch(int len, int flavor);
        for (int i = 0; i < len; i++) begin
            send_sample(pick_sample(flavor), i == len - 1);
        end
    endtask

    // Stop offering samples until every predicted median has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (medians_pending != 0);
    endtask

    initial begin : stimulus
        int pick;
        int len;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-sample batches at both extremes
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sh8000_0000, 1'b1);
        // pairs: largest sum, smallest sum, mixed sign
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        // odd count, arrival out of order
        send_sample(32'sd5, 1'b0);
        send_sample(-32'sd5, 1'b0);
        send_sample(32'sd0, 1'b1);
        // even count with ties, odd sum
        send_sample(32'sd0, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd0, 1'b1);
        // all equal
        repeat (4) send_sample(32'sd7, 1'b0);
        send_sample(32'sd7, 1'b1);
        drain();

        // Random batches in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 20; rx_stall_pct = 58; end
                1: begin tx_idle_pct = 58; rx_stall_pct = 20; end
                default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            endcase
            while (samples_sent < (ph + 1) * TOTAL_SAMPLES / 3) begin
                if (ph == 0 && samples_sent >= 150 && samples_sent < 160) begin
                    long_hold_req = 1'b1;
                end
                // mostly short batches, some mid-size, a few near or past capacity
                pick = $urandom_range(99);
                if (pick < 70) begin
                    len = $urandom_range(12, 1);
                end else if (pick < 90) begin
                    len = $urandom_range(40, 13);
                end else begin
                    len = $urandom_range(MAX_ITEMS + 16, MAX_ITEMS - 8);
                end
                send_batch(len, $urandom_range(2));
            end
            drain();
        end

        // Let the block settle, then give the verdict
        repeat (40) @(posedge clk);
        if (fail_count == 0 && medians_pending == 0) begin
            $display("** batch_median_finder_top: PASSED **");
        end else begin
            $display("** batch_median_finder_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bmf_pkg.sv
rtl/bmf_cell.sv
rtl/bmf_chain.sv
rtl/batch_median_finder_top.sv
sim/batch_median_checker.sv
sim/tb_top.sv
